// ===== hw/rtl/hlm_pkg.sv =====
// ----------------------------------------------------------------------------
// hlm_pkg
// Shared constants, types and helpers of the high/low midpoint line block.
// ----------------------------------------------------------------------------
package hlm_pkg;

   // ring depth, a power of two; slot and read-address arithmetic wrap explicitly
   localparam int WINDOW_MAX  = 64;
   localparam int PRICE_WIDTH = 32;
   localparam int SLOT_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int SEEN_CAP    = (WINDOW_MAX > 64) ? WINDOW_MAX : 64;
   localparam int SEEN_W      = $clog2(SEEN_CAP + 1);
   localparam int PERIOD_W    = 7;
   localparam int LAG_W       = 6;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 7;

   typedef logic [PRICE_WIDTH-1:0] price_type;
   typedef logic [SLOT_W-1:0]      slot_type;
   typedef logic [SEEN_W-1:0]      count_type;
   typedef logic [PERIOD_W-1:0]    period_type;
   typedef logic [LAG_W-1:0]       lag_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHORT_PERIOD = 3'd0,
      CSR_MID_PERIOD   = 3'd1,
      CSR_LONG_PERIOD  = 3'd2,
      CSR_LAG_SHIFT    = 3'd3
   } csr_index_type;

   localparam period_type RESET_SHORT = period_type'(9);
   localparam period_type RESET_MID   = period_type'(26);
   localparam period_type RESET_LONG  = period_type'(52);
   localparam lag_type    RESET_LAG   = lag_type'(26);

   localparam count_type WIN_CNT  = count_type'(WINDOW_MAX);
   localparam count_type SEEN_MAX = count_type'(SEEN_CAP);
   localparam slot_type  SLOT_TOP = slot_type'(WINDOW_MAX - 1);

   typedef struct packed {
      price_type hi;
      price_type lo;
   } ext_type;

   typedef struct packed {
      logic      wr_en;
      slot_type  wr_slot;
      price_type wr_high;
      price_type wr_low;
      logic      start;
      slot_type  top_slot;
      count_type n_short;
      count_type n_mid;
      count_type n_long;
      count_type n_max;
   } scan_ctrl_type;

   typedef struct packed {
      logic    done;
      ext_type ext_short;
      ext_type ext_mid;
      ext_type ext_long;
   } scan_res_type;

   function automatic count_type clamp_period(period_type p, count_type avail);
      count_type n;
      n = count_type'(p);
      if (n == '0) n = count_type'(1);
      if (n > WIN_CNT) n = WIN_CNT;
      if (n > avail) n = avail;
      return n;
   endfunction

endpackage

// ===== hw/rtl/hlm_scan.sv =====
// ----------------------------------------------------------------------------
// hlm_scan
// Bar rings and the shared max/min compare unit that walks the newest bars,
// capturing the extremes of each window as its length is reached.
// ----------------------------------------------------------------------------
module hlm_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  hlm_pkg::scan_ctrl_type ctrl,
   output hlm_pkg::scan_res_type  res
);
   import hlm_pkg::*;

   localparam int ADDR_SUM_W = SLOT_W + 2;
   localparam logic [ADDR_SUM_W-1:0] WIN_SUM = ADDR_SUM_W'(WINDOW_MAX);

   price_type high_mem [WINDOW_MAX];
   price_type low_mem  [WINDOW_MAX];

   price_type rd_hi_ff;
   price_type rd_lo_ff;
   logic      busy_ff;
   logic      rvalid_ff;
   count_type issue_ff;
   count_type seen_ff;
   price_type hh_ff;
   price_type ll_ff;
   logic      done_ff;
   ext_type   ext_short_ff;
   ext_type   ext_mid_ff;
   ext_type   ext_long_ff;

   logic [ADDR_SUM_W-1:0] addr_sum;
   slot_type              rd_addr;
   price_type             hh_in;
   price_type             ll_in;
   count_type             seen_in;

   // newest slot minus issue count, modulo ring depth
   always_comb begin
      addr_sum = ADDR_SUM_W'(ctrl.top_slot) + WIN_SUM - ADDR_SUM_W'(1)
               - ADDR_SUM_W'(issue_ff);
      if (addr_sum >= WIN_SUM) addr_sum = addr_sum - WIN_SUM;
      rd_addr = addr_sum[SLOT_W-1:0];
   end

   always_comb begin
      hh_in   = (rd_hi_ff > hh_ff) ? rd_hi_ff : hh_ff;
      ll_in   = (rd_lo_ff < ll_ff) ? rd_lo_ff : ll_ff;
      seen_in = seen_ff + count_type'(1);
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         high_mem[ctrl.wr_slot] <= ctrl.wr_high;
         low_mem[ctrl.wr_slot]  <= ctrl.wr_low;
      end
      rd_hi_ff <= high_mem[rd_addr];
      rd_lo_ff <= low_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
         issue_ff  <= '0;
         seen_ff   <= '0;
         done_ff   <= 1'b0;
      end else if (ctrl.start) begin
         busy_ff   <= 1'b1;
         rvalid_ff <= 1'b0;
         issue_ff  <= '0;
         seen_ff   <= '0;
         done_ff   <= 1'b0;
         hh_ff     <= '0;
         ll_ff     <= '1;
      end else if (busy_ff) begin
         if (issue_ff < ctrl.n_max) begin
            issue_ff  <= issue_ff + count_type'(1);
            rvalid_ff <= 1'b1;
         end else begin
            rvalid_ff <= 1'b0;
         end
         if (rvalid_ff) begin
            hh_ff   <= hh_in;
            ll_ff   <= ll_in;
            seen_ff <= seen_in;
            if (seen_in == ctrl.n_short) ext_short_ff <= '{hi: hh_in, lo: ll_in};
            if (seen_in == ctrl.n_mid)   ext_mid_ff   <= '{hi: hh_in, lo: ll_in};
            if (seen_in == ctrl.n_long)  ext_long_ff  <= '{hi: hh_in, lo: ll_in};
            if (seen_in == ctrl.n_max) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign res = '{done:      done_ff,
                  ext_short: ext_short_ff,
                  ext_mid:   ext_mid_ff,
                  ext_long:  ext_long_ff};

endmodule

// ===== hw/rtl/windowed_high_low_midpoint_lines_top.sv =====
// ----------------------------------------------------------------------------
// windowed_high_low_midpoint_lines_top
// Midpoint lines over short, mid and long bar windows, span A and lagging
// close, from a ring of bars walked by one shared compare unit.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  bar_high, bar_low, bar_close
//   rsp      out        rsp_valid / rsp_stall  six line fields
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// one request scans n ring entries, n the longest clamped window (1 to 64),
// the compare unit reading one ring entry per cycle
// req_stall is high from acceptance until the result sits in the output
// register; a stalled result holds there while the next request is taken
// synchronous active-high reset; the rings need no clearing
// ----------------------------------------------------------------------------
module windowed_high_low_midpoint_lines_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  hlm_pkg::price_type            req_bar_high,
   input  hlm_pkg::price_type            req_bar_low,
   input  hlm_pkg::price_type            req_bar_close,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output hlm_pkg::price_type            rsp_conversion_line,
   output hlm_pkg::price_type            rsp_base_line,
   output hlm_pkg::price_type            rsp_lead_span_a,
   output hlm_pkg::price_type            rsp_lead_span_b,
   output hlm_pkg::price_type            rsp_lagging_value,
   output logic                          rsp_lagging_valid,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [hlm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hlm_pkg::CSR_DATA_W-1:0] csr_data
);
   import hlm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_COMBINE
   } state_type;

   typedef enum logic [1:0] {
      PH_CONV,
      PH_BASE,
      PH_SPANB,
      PH_SPANA
   } phase_type;

   state_type  state_ff;
   phase_type  phase_ff;
   period_type short_ff;
   period_type mid_ff;
   period_type long_ff;
   lag_type    lag_ff;
   slot_type   slot_ff;
   count_type  seen_ff;
   price_type  close_ff;
   logic       lag_ok_ff;
   price_type  conv_ff;
   price_type  base_ff;
   price_type  spanb_ff;

   logic       rsp_valid_ff;
   price_type  out_conv_ff;
   price_type  out_base_ff;
   price_type  out_spana_ff;
   price_type  out_spanb_ff;
   price_type  out_close_ff;
   logic       out_lag_ok_ff;

   logic              accept;
   logic              out_free;
   logic              load_out;
   count_type         avail;
   count_type         n_short;
   count_type         n_mid;
   count_type         n_long;
   count_type         n_max;
   price_type         op_a;
   price_type         op_b;
   logic [PRICE_WIDTH:0] sum;
   price_type         mid_val;
   scan_ctrl_type     ctrl;
   scan_res_type      res;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_out  = (state_ff == ST_COMBINE) && (phase_ff == PH_SPANA) && out_free;
   assign csr_ready = 1'b1;

   always_comb begin
      avail   = (seen_ff > WIN_CNT) ? WIN_CNT : seen_ff;
      n_short = clamp_period(short_ff, avail);
      n_mid   = clamp_period(mid_ff, avail);
      n_long  = clamp_period(long_ff, avail);
      n_max   = (n_short > n_mid) ? n_short : n_mid;
      if (n_long > n_max) n_max = n_long;
   end

   always_comb begin
      ctrl.wr_en    = accept;
      ctrl.wr_slot  = slot_ff;
      ctrl.wr_high  = req_bar_high;
      ctrl.wr_low   = req_bar_low;
      ctrl.start    = (state_ff == ST_START);
      ctrl.top_slot = slot_ff;
      ctrl.n_short  = n_short;
      ctrl.n_mid    = n_mid;
      ctrl.n_long   = n_long;
      ctrl.n_max    = n_max;
   end

   hlm_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .res   (res)
   );

   // shared midpoint adder
   always_comb begin
      unique case (phase_ff)
         PH_CONV: begin
            op_a = res.ext_short.hi;
            op_b = res.ext_short.lo;
         end
         PH_BASE: begin
            op_a = res.ext_mid.hi;
            op_b = res.ext_mid.lo;
         end
         PH_SPANB: begin
            op_a = res.ext_long.hi;
            op_b = res.ext_long.lo;
         end
         PH_SPANA: begin
            op_a = conv_ff;
            op_b = base_ff;
         end
         default: begin
            op_a = conv_ff;
            op_b = base_ff;
         end
      endcase
      sum     = {1'b0, op_a} + {1'b0, op_b};
      mid_val = sum[PRICE_WIDTH:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff <= RESET_SHORT;
         mid_ff   <= RESET_MID;
         long_ff  <= RESET_LONG;
         lag_ff   <= RESET_LAG;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SHORT_PERIOD: short_ff <= csr_data;
            CSR_MID_PERIOD:   mid_ff   <= csr_data;
            CSR_LONG_PERIOD:  long_ff  <= csr_data;
            CSR_LAG_SHIFT:    lag_ff   <= csr_data[LAG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_CONV;
         slot_ff      <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  close_ff  <= req_bar_close;
                  lag_ok_ff <= (seen_ff >= count_type'(lag_ff));
                  slot_ff   <= (slot_ff == SLOT_TOP) ? '0 : slot_ff + slot_type'(1);
                  if (seen_ff < SEEN_MAX) seen_ff <= seen_ff + count_type'(1);
                  state_ff  <= ST_START;
               end
            end
            ST_START: begin
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (res.done) begin
                  phase_ff <= PH_CONV;
                  state_ff <= ST_COMBINE;
               end
            end
            ST_COMBINE: begin
               unique case (phase_ff)
                  PH_CONV: begin
                     conv_ff  <= mid_val;
                     phase_ff <= PH_BASE;
                  end
                  PH_BASE: begin
                     base_ff  <= mid_val;
                     phase_ff <= PH_SPANB;
                  end
                  PH_SPANB: begin
                     spanb_ff <= mid_val;
                     phase_ff <= PH_SPANA;
                  end
                  PH_SPANA: begin
                     if (out_free) begin
                        out_conv_ff   <= conv_ff;
                        out_base_ff   <= base_ff;
                        out_spana_ff  <= mid_val;
                        out_spanb_ff  <= spanb_ff;
                        out_close_ff  <= close_ff;
                        out_lag_ok_ff <= lag_ok_ff;
                        phase_ff      <= PH_CONV;
                        state_ff      <= ST_IDLE;
                     end
                  end
                  default: phase_ff <= PH_CONV;
               endcase
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_conversion_line = out_conv_ff;
   assign rsp_base_line       = out_base_ff;
   assign rsp_lead_span_a     = out_spana_ff;
   assign rsp_lead_span_b     = out_spanb_ff;
   assign rsp_lagging_value   = out_close_ff;
   assign rsp_lagging_valid   = out_lag_ok_ff;

endmodule

// ===== hw/rtl/hlm_check.sv =====
// ----------------------------------------------------------------------------
// hlm_check
// Port-level checks of the midpoint line block, bound to the top level.
// ----------------------------------------------------------------------------
module hlm_check (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input hlm_pkg::price_type rsp_conversion_line,
   input hlm_pkg::price_type rsp_base_line,
   input hlm_pkg::price_type rsp_lead_span_a
);

   // a request keeps the block busy for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in progress");

   // stalled response stays valid and keeps its span a
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_lead_span_a))
      else $error("stalled response changed");

   // span a lies between conversion and base lines
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_lead_span_a >= rsp_conversion_line
                     || rsp_lead_span_a >= rsp_base_line)
                 && (rsp_lead_span_a <= rsp_conversion_line
                     || rsp_lead_span_a <= rsp_base_line))
      else $error("span a outside its operands");

   // reset empties the output
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind windowed_high_low_midpoint_lines_top hlm_check u_hlm_check (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_conversion_line (rsp_conversion_line),
   .rsp_base_line       (rsp_base_line),
   .rsp_lead_span_a     (rsp_lead_span_a)
);
